// File: rtl/sjt_pkg.sv
// shared types, constants and tables of the sine joint trajectory generator
`default_nettype none

package sjt_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_AMPLITUDE       = 3'd0;
    localparam logic [2:0] REG_FREQUENCY_HZ    = 3'd1;
    localparam logic [2:0] REG_PHASE_OFFSET    = 3'd2;
    localparam logic [2:0] REG_CENTER_POSITION = 3'd3;
    localparam logic [2:0] REG_POSITION_GAIN   = 3'd4;
    localparam logic [2:0] REG_VELOCITY_GAIN   = 3'd5;
    localparam logic [2:0] REG_TICK_PERIOD     = 3'd6;
    localparam logic [2:0] REG_END_TIME        = 3'd7;

    localparam logic [31:0] TICK_PERIOD_RESET = 32'd4294967;
    localparam logic [31:0] END_TIME_RESET    = 32'd65536000;

    localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [47:0] LIM            = 48'h8000_0000_0000;
    localparam logic [47:0] TIME_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam logic [4:0]  MUL_LAST       = 5'd31;

    typedef logic signed [50:0] wide_t;
    typedef logic signed [33:0] cval_t;

    localparam cval_t CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic [31:0] amplitude;
        logic [31:0] frequency_hz;
        logic [31:0] phase_offset;
        logic [31:0] center_position;
        logic [31:0] position_gain;
        logic [31:0] velocity_gain;
        logic [31:0] tick_period;
        logic [31:0] end_time;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [47:0] m;
        logic [31:0] g;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [79:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic  start;
        cval_t z;
    } cordic_req_t;

    typedef struct packed {
        logic  done;
        cval_t x;
        cval_t y;
    } cordic_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG_F,
        ST_ANG_P,
        ST_ZMUL,
        ST_CORDIC,
        ST_MUL_S,
        ST_MUL_C,
        ST_RAMP_V,
        ST_RAMP_A,
        ST_FV1,
        ST_FV2,
        ST_FA1,
        ST_FA2,
        ST_FA3,
        ST_FA4,
        ST_KP,
        ST_KD,
        ST_TICK,
        ST_TIME,
        ST_OUT
    } state_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sine_joint_trajectory_pd_top.sv
// top level of the sine joint trajectory generator with pd feedback
// usage:
//   configure the eight registers over apb while the block is idle; register i
//   sits at byte address 4*i, writes complete in the access cycle, pready is
//   always high and reads return the stored value.
//   each input word (restart, measured position and velocity) is one servo tick
//   and gives exactly one output word (desired position, velocity,
//   acceleration and phase_done).
//   one word is processed at a time: a bit-serial 48x32 multiplier forms the
//   products one after another and the cordic runs after the angle products. a tick
//   uses 14 products (16 while elapsed time is under 4 s). the result sits in
//   an output register, so the next input word is accepted while it waits; a
//   stalled receiver holds the sequencer at its final step.
//   reset clears the tick counter, elapsed time and the output valid, and
//   restores the register reset values.
`default_nettype none

module sine_joint_trajectory_pd_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sjt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       restart,
    input  logic signed [31:0]         measured_position,
    input  logic signed [31:0]         measured_velocity,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [31:0]         desired_position,
    output logic signed [31:0]         desired_velocity,
    output logic signed [31:0]         desired_acceleration,
    output logic                       phase_done
);

    sjt_pkg::cfg_t cfg;

    sjt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sjt_core u_core (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .restart              (restart),
        .measured_position    (measured_position),
        .measured_velocity    (measured_velocity),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .desired_position     (desired_position),
        .desired_velocity     (desired_velocity),
        .desired_acceleration (desired_acceleration),
        .phase_done           (phase_done)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an accepted word");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result word appeared one cycle after accept");

    a_amp_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[sjt_pkg::ADDR_W-1:2] == sjt_pkg::REG_AMPLITUDE))
        |=> (cfg.amplitude == $past(pwdata)))
        else $error("amplitude register not written");
`endif

endmodule

`default_nettype wire

// File: rtl/sjt_mul.sv
// bit-serial 48 x 32 unsigned shift-add multiplier
`default_nettype none

module sjt_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  sjt_pkg::mul_req_t req,
    output sjt_pkg::mul_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [47:0] m_reg;
    logic [79:0] p_reg;
    logic [48:0] sum;
    logic [79:0] p_step;

    always_comb
    begin
        sum    = {1'b0, p_reg[79:32]} + (p_reg[0] ? {1'b0, m_reg} : 49'd0);
        p_step = {sum, p_reg[31:1]};
        rsp.done = done_reg;
        rsp.p    = p_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == sjt_pkg::MUL_LAST) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == sjt_pkg::MUL_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            m_reg <= req.m;
            p_reg <= {48'd0, req.g};
        end
        else if (busy_reg)
        begin
            p_reg <= p_step;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sjt_cordic.sv
// iterative rotation-mode cordic, one step per cycle
`default_nettype none

module sjt_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sjt_pkg::cordic_req_t req,
    output sjt_pkg::cordic_rsp_t rsp
);

    localparam logic [4:0] LAST = 5'(sjt_pkg::CORDIC_ITERS - 1);

    logic           busy_reg;
    logic           done_reg;
    logic [4:0]     cnt_reg;
    sjt_pkg::cval_t x_reg;
    sjt_pkg::cval_t y_reg;
    sjt_pkg::cval_t z_reg;
    sjt_pkg::cval_t dx;
    sjt_pkg::cval_t dy;
    sjt_pkg::cval_t at;

    always_comb
    begin
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        at = $signed({4'd0, sjt_pkg::atan_q30(cnt_reg)});
        rsp.done = done_reg;
        rsp.x    = x_reg;
        rsp.y    = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= sjt_pkg::CORDIC_GAIN_Q30;
            y_reg <= '0;
            z_reg <= req.z;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sjt_regs.sv
// apb configuration register file
`default_nettype none

module sjt_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sjt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output sjt_pkg::cfg_t              cfg
);

    sjt_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[sjt_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude       <= 32'd0;
            cfg_reg.frequency_hz    <= 32'd0;
            cfg_reg.phase_offset    <= 32'd0;
            cfg_reg.center_position <= 32'd0;
            cfg_reg.position_gain   <= 32'd0;
            cfg_reg.velocity_gain   <= 32'd0;
            cfg_reg.tick_period     <= sjt_pkg::TICK_PERIOD_RESET;
            cfg_reg.end_time        <= sjt_pkg::END_TIME_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                sjt_pkg::REG_AMPLITUDE:       cfg_reg.amplitude       <= pwdata;
                sjt_pkg::REG_FREQUENCY_HZ:    cfg_reg.frequency_hz    <= pwdata;
                sjt_pkg::REG_PHASE_OFFSET:    cfg_reg.phase_offset    <= pwdata;
                sjt_pkg::REG_CENTER_POSITION: cfg_reg.center_position <= pwdata;
                sjt_pkg::REG_POSITION_GAIN:   cfg_reg.position_gain   <= pwdata;
                sjt_pkg::REG_VELOCITY_GAIN:   cfg_reg.velocity_gain   <= pwdata;
                sjt_pkg::REG_TICK_PERIOD:     cfg_reg.tick_period     <= pwdata;
                sjt_pkg::REG_END_TIME:        cfg_reg.end_time        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sjt_pkg::REG_AMPLITUDE:       prdata = cfg_reg.amplitude;
            sjt_pkg::REG_FREQUENCY_HZ:    prdata = cfg_reg.frequency_hz;
            sjt_pkg::REG_PHASE_OFFSET:    prdata = cfg_reg.phase_offset;
            sjt_pkg::REG_CENTER_POSITION: prdata = cfg_reg.center_position;
            sjt_pkg::REG_POSITION_GAIN:   prdata = cfg_reg.position_gain;
            sjt_pkg::REG_VELOCITY_GAIN:   prdata = cfg_reg.velocity_gain;
            sjt_pkg::REG_TICK_PERIOD:     prdata = cfg_reg.tick_period;
            sjt_pkg::REG_END_TIME:        prdata = cfg_reg.end_time;
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/sjt_core.sv
// sequencer and datapath: angle, sine and cosine, ramp, pd and tick update
`default_nettype none

module sjt_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sjt_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    input  logic signed [31:0]  measured_position,
    input  logic signed [31:0]  measured_velocity,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  desired_position,
    output logic signed [31:0]  desired_velocity,
    output logic signed [31:0]  desired_acceleration,
    output logic                phase_done
);

    localparam sjt_pkg::wide_t S32_MAX = 51'sd2147483647;
    localparam sjt_pkg::wide_t S32_MIN = -51'sd2147483648;

    function automatic logic [47:0] mag_lim(input sjt_pkg::wide_t v);
        logic [50:0] a;
        a = v[50] ? 51'(-v) : 51'(v);
        return (a > 51'(sjt_pkg::LIM)) ? sjt_pkg::LIM : a[47:0];
    endfunction

    function automatic logic [31:0] sat32(input sjt_pkg::wide_t v);
        logic [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    sjt_pkg::state_t      state_reg;
    sjt_pkg::state_t      state_next;
    logic                 issued_reg;
    logic [31:0]          tc_reg;
    logic [47:0]          et_reg;
    logic                 out_valid_reg;

    logic signed [31:0]   mpos_reg;
    logic signed [31:0]   mvel_reg;
    logic [31:0]          ang_reg;
    sjt_pkg::cval_t       zin_reg;
    sjt_pkg::cval_t       s_reg;
    sjt_pkg::cval_t       c_reg;
    sjt_pkg::wide_t       pos_reg;
    sjt_pkg::wide_t       vel_reg;
    sjt_pkg::wide_t       acc_reg;
    sjt_pkg::wide_t       tp_reg;
    logic [31:0]          dpos_reg;
    logic [31:0]          dvel_reg;
    logic [31:0]          dacc_reg;
    logic                 pdone_reg;

    sjt_pkg::mul_req_t    mul_req;
    sjt_pkg::mul_rsp_t    mul_rsp;
    sjt_pkg::cordic_req_t cordic_req;
    sjt_pkg::cordic_rsp_t cordic_rsp;

    logic                 accept;
    logic                 mul_state;
    logic                 unit_done;
    logic                 out_load;
    logic                 ramp_on;
    logic                 op_direct;
    logic                 op_use_sc;
    logic [47:0]          op_m;
    logic [31:0]          op_g;
    logic                 op_neg;
    sjt_pkg::wide_t       op_v;
    sjt_pkg::cval_t       op_sc;
    logic [47:0]          sc_mag;
    logic [79:0]          ps;
    sjt_pkg::cval_t       term;
    logic [63:0]          shifted;
    logic [47:0]          clamped;
    sjt_pkg::wide_t       ms_val;

    sjt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    sjt_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    assign accept    = in_valid && (state_reg == sjt_pkg::ST_IDLE);
    assign mul_state = (state_reg != sjt_pkg::ST_IDLE) && (state_reg != sjt_pkg::ST_CORDIC)
                    && (state_reg != sjt_pkg::ST_TICK) && (state_reg != sjt_pkg::ST_OUT);
    assign unit_done = mul_rsp.done || cordic_rsp.done;
    assign out_load  = (state_reg == sjt_pkg::ST_OUT) && (!out_valid_reg || out_ready);
    assign ramp_on   = (et_reg[47:34] == 14'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sjt_pkg::ST_IDLE:   if (in_valid) state_next = sjt_pkg::ST_ANG_F;
            sjt_pkg::ST_ANG_F:  if (mul_rsp.done) state_next = sjt_pkg::ST_ANG_P;
            sjt_pkg::ST_ANG_P:  if (mul_rsp.done) state_next = sjt_pkg::ST_ZMUL;
            sjt_pkg::ST_ZMUL:   if (mul_rsp.done) state_next = sjt_pkg::ST_CORDIC;
            sjt_pkg::ST_CORDIC: if (cordic_rsp.done) state_next = sjt_pkg::ST_MUL_S;
            sjt_pkg::ST_MUL_S:  if (mul_rsp.done) state_next = sjt_pkg::ST_MUL_C;
            sjt_pkg::ST_MUL_C:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ramp_on ? sjt_pkg::ST_RAMP_V : sjt_pkg::ST_FV1;
                end
            end
            sjt_pkg::ST_RAMP_V: if (mul_rsp.done) state_next = sjt_pkg::ST_RAMP_A;
            sjt_pkg::ST_RAMP_A: if (mul_rsp.done) state_next = sjt_pkg::ST_FV1;
            sjt_pkg::ST_FV1:    if (mul_rsp.done) state_next = sjt_pkg::ST_FV2;
            sjt_pkg::ST_FV2:    if (mul_rsp.done) state_next = sjt_pkg::ST_FA1;
            sjt_pkg::ST_FA1:    if (mul_rsp.done) state_next = sjt_pkg::ST_FA2;
            sjt_pkg::ST_FA2:    if (mul_rsp.done) state_next = sjt_pkg::ST_FA3;
            sjt_pkg::ST_FA3:    if (mul_rsp.done) state_next = sjt_pkg::ST_FA4;
            sjt_pkg::ST_FA4:    if (mul_rsp.done) state_next = sjt_pkg::ST_KP;
            sjt_pkg::ST_KP:     if (mul_rsp.done) state_next = sjt_pkg::ST_KD;
            sjt_pkg::ST_KD:     if (mul_rsp.done) state_next = sjt_pkg::ST_TICK;
            sjt_pkg::ST_TICK:   state_next = sjt_pkg::ST_TIME;
            sjt_pkg::ST_TIME:   if (mul_rsp.done) state_next = sjt_pkg::ST_OUT;
            sjt_pkg::ST_OUT:    if (out_load) state_next = sjt_pkg::ST_IDLE;
            default:            state_next = sjt_pkg::ST_IDLE;
        endcase
    end

    // operand select and unit requests
    always_comb
    begin
        op_v      = '0;
        op_sc     = '0;
        op_m      = '0;
        op_g      = '0;
        op_direct = 1'b0;
        op_use_sc = 1'b0;
        in_ready  = (state_reg == sjt_pkg::ST_IDLE);
        unique case (state_reg) inside
            sjt_pkg::ST_ANG_F:
            begin
                op_direct = 1'b1;
                op_m      = et_reg;
                op_g      = cfg.frequency_hz;
            end
            sjt_pkg::ST_ANG_P:
            begin
                op_v = sjt_pkg::wide_t'($signed(cfg.phase_offset));
                op_g = sjt_pkg::INV_TWO_PI_Q32;
            end
            sjt_pkg::ST_ZMUL:
            begin
                op_direct = 1'b1;
                op_m      = {18'd0, ang_reg[29:0]};
                op_g      = sjt_pkg::TWO_PI_Q29;
            end
            sjt_pkg::ST_MUL_S:
            begin
                op_v      = sjt_pkg::wide_t'($signed(cfg.amplitude));
                op_sc     = s_reg;
                op_use_sc = 1'b1;
            end
            sjt_pkg::ST_MUL_C:
            begin
                op_v      = sjt_pkg::wide_t'($signed(cfg.amplitude));
                op_sc     = c_reg;
                op_use_sc = 1'b1;
            end
            sjt_pkg::ST_RAMP_V:
            begin
                op_v = vel_reg;
                op_g = et_reg[33:2];
            end
            sjt_pkg::ST_RAMP_A:
            begin
                op_v = acc_reg;
                op_g = et_reg[33:2];
            end
            sjt_pkg::ST_FV1:
            begin
                op_v = vel_reg;
                op_g = cfg.frequency_hz;
            end
            sjt_pkg::ST_FV2:
            begin
                op_v = vel_reg;
                op_g = sjt_pkg::TWO_PI_Q29;
            end
            sjt_pkg::ST_FA1, sjt_pkg::ST_FA3:
            begin
                op_v = acc_reg;
                op_g = cfg.frequency_hz;
            end
            sjt_pkg::ST_FA2, sjt_pkg::ST_FA4:
            begin
                op_v = acc_reg;
                op_g = sjt_pkg::TWO_PI_Q29;
            end
            sjt_pkg::ST_KP:
            begin
                op_v = pos_reg - sjt_pkg::wide_t'(mpos_reg);
                op_g = cfg.position_gain;
            end
            sjt_pkg::ST_KD:
            begin
                op_v = vel_reg - sjt_pkg::wide_t'(mvel_reg);
                op_g = cfg.velocity_gain;
            end
            sjt_pkg::ST_TIME:
            begin
                op_direct = 1'b1;
                op_m      = {16'd0, tc_reg};
                op_g      = cfg.tick_period;
            end
            default: ;
        endcase
        sc_mag = mag_lim(sjt_pkg::wide_t'(op_sc));
        if (op_use_sc)
        begin
            op_g = sc_mag[31:0];
        end
        if (!op_direct)
        begin
            op_m = mag_lim(op_v);
        end
        op_neg = op_v[50] ^ op_sc[33];

        mul_req.start    = mul_state && !issued_reg;
        mul_req.m        = op_m;
        mul_req.g        = op_g;
        cordic_req.start = (state_reg == sjt_pkg::ST_CORDIC) && !issued_reg;
        cordic_req.z     = zin_reg;
    end

    // product post-processing
    always_comb
    begin
        ps   = op_neg ? (~mul_rsp.p + 80'd1) : mul_rsp.p;
        term = ps[63:30];
        case (state_reg) inside
            sjt_pkg::ST_RAMP_V, sjt_pkg::ST_RAMP_A:
                shifted = {16'd0, mul_rsp.p[79:32]};
            sjt_pkg::ST_FV2, sjt_pkg::ST_FA2, sjt_pkg::ST_FA4:
                shifted = {13'd0, mul_rsp.p[79:29]};
            default:
                shifted = mul_rsp.p[79:16];
        endcase
        clamped = (shifted > 64'(sjt_pkg::LIM)) ? sjt_pkg::LIM : shifted[47:0];
        ms_val  = op_neg ? -sjt_pkg::wide_t'({3'd0, clamped})
                         : sjt_pkg::wide_t'({3'd0, clamped});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sjt_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            tc_reg        <= 32'd0;
            et_reg        <= 48'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (unit_done)
            begin
                issued_reg <= 1'b0;
            end
            else if (mul_req.start || cordic_req.start)
            begin
                issued_reg <= 1'b1;
            end
            if (accept && restart)
            begin
                tc_reg <= 32'd0;
                et_reg <= 48'd0;
            end
            else if (state_reg == sjt_pkg::ST_TICK)
            begin
                if (tc_reg != 32'hFFFF_FFFF)
                begin
                    tc_reg <= tc_reg + 32'd1;
                end
            end
            else if ((state_reg == sjt_pkg::ST_TIME) && mul_rsp.done)
            begin
                et_reg <= (mul_rsp.p[79:48] != 32'd0) ? sjt_pkg::TIME_MAX : mul_rsp.p[47:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mpos_reg <= measured_position;
            mvel_reg <= measured_velocity;
        end
        if (cordic_rsp.done)
        begin
            case (ang_reg[31:30])
                2'd0:
                begin
                    s_reg <= cordic_rsp.y;
                    c_reg <= cordic_rsp.x;
                end
                2'd1:
                begin
                    s_reg <= cordic_rsp.x;
                    c_reg <= -cordic_rsp.y;
                end
                2'd2:
                begin
                    s_reg <= -cordic_rsp.y;
                    c_reg <= -cordic_rsp.x;
                end
                default:
                begin
                    s_reg <= -cordic_rsp.x;
                    c_reg <= cordic_rsp.y;
                end
            endcase
        end
        if (mul_rsp.done)
        begin
            case (state_reg) inside
                sjt_pkg::ST_ANG_F: ang_reg <= mul_rsp.p[47:16];
                sjt_pkg::ST_ANG_P: ang_reg <= ang_reg + ps[55:24];
                sjt_pkg::ST_ZMUL:  zin_reg <= $signed({3'd0, mul_rsp.p[61:31]});
                sjt_pkg::ST_MUL_S:
                begin
                    pos_reg <= sjt_pkg::wide_t'($signed(cfg.center_position))
                             + sjt_pkg::wide_t'(term);
                    acc_reg <= -sjt_pkg::wide_t'(term);
                end
                sjt_pkg::ST_MUL_C: vel_reg <= sjt_pkg::wide_t'(term);
                sjt_pkg::ST_RAMP_V, sjt_pkg::ST_FV1, sjt_pkg::ST_FV2: vel_reg <= ms_val;
                sjt_pkg::ST_RAMP_A, sjt_pkg::ST_FA1, sjt_pkg::ST_FA2,
                sjt_pkg::ST_FA3, sjt_pkg::ST_FA4: acc_reg <= ms_val;
                sjt_pkg::ST_KP:    tp_reg <= ms_val;
                sjt_pkg::ST_KD:    acc_reg <= acc_reg + tp_reg + ms_val;
                default: ;
            endcase
        end
        if (out_load)
        begin
            dpos_reg  <= sat32(pos_reg);
            dvel_reg  <= sat32(vel_reg);
            dacc_reg  <= sat32(acc_reg);
            pdone_reg <= (et_reg > {cfg.end_time, 16'd0});
        end
    end

    assign out_valid            = out_valid_reg;
    assign desired_position     = $signed(dpos_reg);
    assign desired_velocity     = $signed(dvel_reg);
    assign desired_acceleration = $signed(dacc_reg);
    assign phase_done           = pdone_reg;

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for the sine joint trajectory generator: predicts each output word and checks it
`default_nettype none

class trajectory_scoreboard;
    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic        done;
    } traj_word_t;

    logic [31:0] regs [8];
    logic [31:0] ticks;
    logic [63:0] elapsed;
    traj_word_t  pending [$];
    int          errors;

    function new();
        regs[0] = 0; regs[1] = 0; regs[2] = 0; regs[3] = 0;
        regs[4] = 0; regs[5] = 0;
        regs[6] = sjt_pkg::TICK_PERIOD_RESET;
        regs[7] = sjt_pkg::END_TIME_RESET;
        ticks = 0;
        elapsed = 0;
        errors = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
        if (idx < 8) regs[idx] = val;
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint scale_clamp(longint v, logic [31:0] g, int f);
        logic        neg;
        logic [63:0] m, ph, pl, q, r, lim;
        lim = 64'd1 << 47;
        neg = v < 0;
        m = neg ? 64'd0 - 64'(v) : 64'(v);
        if (m > lim) m = lim;
        ph = (m >> 24) * {32'd0, g};
        pl = (m & 64'hFFFFFF) * {32'd0, g};
        q = ph + (pl >> 24);
        if (f >= 24) r = q >> (f - 24);
        else if (q > (lim >> (24 - f))) r = lim;
        else r = (q << (24 - f)) + ((pl & 64'hFFFFFF) >> f);
        if (r > lim) r = lim;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    static function logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    static function void sin_cos(logic [31:0] ang, output longint s, output longint c);
        logic [63:0] res;
        longint x, y, z, dx, dy;
        res = {34'd0, ang[29:0]};
        x = sjt_pkg::CORDIC_GAIN_Q30;
        y = 0;
        z = longint'((res * 64'(sjt_pkg::TWO_PI_Q29)) >> 31);
        for (int i = 0; i < sjt_pkg::CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(sjt_pkg::atan_q30(5'(i)));
            end
            else begin
                x += dx; y -= dy; z += longint'(sjt_pkg::atan_q30(5'(i)));
            end
        end
        case (ang[31:30])
            2'd0: begin s = y;  c = x;  end
            2'd1: begin s = x;  c = -y; end
            2'd2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function void note_tick(logic rst, logic [31:0] mpos, logic [31:0] mvel);
        longint amp, center, s, c, pos, vel, acc, tp, td, ph;
        logic [31:0] ang, rr;
        logic [63:0] prod;
        traj_word_t w;
        amp = longint'($signed(regs[0]));
        center = longint'($signed(regs[3]));
        if (rst) begin
            ticks = 0;
            elapsed = 0;
        end
        prod = {32'd0, regs[1]} * elapsed;
        ang = prod[47:16];
        ph = longint'($signed(regs[2])) * longint'(sjt_pkg::INV_TWO_PI_Q32);
        ang += ph[55:24];
        sin_cos(ang, s, c);
        pos = center + (amp * s >>> 30);
        vel = amp * c >>> 30;
        acc = -(amp * s >>> 30);
        if (elapsed < (64'd4 << 32)) begin
            rr = elapsed[33:2];
            vel = scale_clamp(vel, rr, 32);
            acc = scale_clamp(acc, rr, 32);
        end
        vel = scale_clamp(scale_clamp(vel, regs[1], 16), sjt_pkg::TWO_PI_Q29, 29);
        acc = scale_clamp(scale_clamp(acc, regs[1], 16), sjt_pkg::TWO_PI_Q29, 29);
        acc = scale_clamp(scale_clamp(acc, regs[1], 16), sjt_pkg::TWO_PI_Q29, 29);
        tp = scale_clamp(pos - longint'($signed(mpos)), regs[4], 16);
        td = scale_clamp(vel - longint'($signed(mvel)), regs[5], 16);
        acc = acc + tp + td;
        if (ticks != 32'hFFFFFFFF) ticks++;
        prod = {32'd0, ticks} * {32'd0, regs[6]};
        elapsed = prod > {16'd0, sjt_pkg::TIME_MAX} ? {16'd0, sjt_pkg::TIME_MAX} : prod;
        w.pos = clip32(pos);
        w.vel = clip32(vel);
        w.acc = clip32(acc);
        w.done = elapsed > ({32'd0, regs[7]} << 16);
        pending.push_back(w);
    endfunction

    function void check_word(logic [31:0] pos, logic [31:0] vel, logic [31:0] acc,
                             logic done);
        traj_word_t w;
        if (pending.size() == 0) begin
            $error("output word with nothing pending");
            errors++;
            return;
        end
        w = pending.pop_front();
        if (pos !== w.pos) begin
            $error("desired_position expected %0d got %0d", $signed(w.pos), $signed(pos));
            errors++;
        end
        if (vel !== w.vel) begin
            $error("desired_velocity expected %0d got %0d", $signed(w.vel), $signed(vel));
            errors++;
        end
        if (acc !== w.acc) begin
            $error("desired_acceleration expected %0d got %0d", $signed(w.acc),
                   $signed(acc));
            errors++;
        end
        if (done !== w.done) begin
            $error("phase_done expected %0d got %0d", w.done, done);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [sjt_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_ready, restart;
    logic signed [31:0] measured_position, measured_velocity;
    logic        out_valid, out_ready;
    logic signed [31:0] desired_position, desired_velocity, desired_acceleration;
    logic        phase_done;

    trajectory_scoreboard sb;
    int          cycles;
    bit          calm;

    sine_joint_trajectory_pd_top u_top (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; restart = 0; measured_position = 0; measured_velocity = 0;
        out_ready = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(desired_position, desired_velocity, desired_acceleration,
                          phase_done);
        if (rst_n)
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(idx, val);
    endtask

    task automatic wait_drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic send_tick(input logic rst, input logic [31:0] mp, input logic [31:0] mv);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        restart <= rst;
        measured_position <= mp;
        measured_velocity <= mv;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(rst, mp, mv);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(3))
            0: return 32'h7FFFFFFF ^ {31'd0, 1'($urandom_range(1))};
            1: return 32'h80000000 | {31'd0, 1'($urandom_range(1))};
            2: return $urandom_range(65535) << $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    task automatic config_set(input int k);
        write_reg(sjt_pkg::REG_AMPLITUDE,
                  k == 0 ? 32'h7FFFFFFF : k == 1 ? 32'h80000000 : $urandom);
        write_reg(sjt_pkg::REG_FREQUENCY_HZ,
                  k == 0 ? 32'hFFFFFFFF : k == 1 ? 32'd0 : $urandom_range(32'h40000));
        write_reg(sjt_pkg::REG_PHASE_OFFSET, k < 2 ? {k[0], {31{~k[0]}}} : $urandom);
        write_reg(sjt_pkg::REG_CENTER_POSITION, k < 2 ? {k[0], {31{~k[0]}}} : $urandom);
        write_reg(sjt_pkg::REG_POSITION_GAIN,
                  k == 0 ? 32'hFFFFFFFF : k == 1 ? 32'd0 : $urandom_range(32'h200000));
        write_reg(sjt_pkg::REG_VELOCITY_GAIN,
                  k == 0 ? 32'hFFFFFFFF : k == 1 ? 32'd0 : $urandom_range(32'h200000));
        write_reg(sjt_pkg::REG_TICK_PERIOD,
                  k == 0 ? 32'hFFFFFFFF : k == 1 ? 32'd0 : $urandom);
        write_reg(sjt_pkg::REG_END_TIME,
                  k == 0 ? 32'd0 : k == 1 ? 32'hFFFFFFFF : $urandom_range(32'h60000));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        calm = 0;
        @(posedge rst_n);
        @(posedge clk);
        // reset settings first
        send_tick(1, 0, 0);
        send_tick(0, 32'h7FFFFFFF, 32'h80000000);
        wait_drain();
        for (int k = 0; k < 2; k++) begin
            config_set(k);
            send_tick(1, 32'h7FFFFFFF, 32'h7FFFFFFF);
            send_tick(0, 32'h80000000, 32'h80000000);
            send_tick(0, 0, 32'hFFFFFFFF);
            send_tick(0, 32'hFFFFFFFF, 0);
            for (int i = 0; i < 6; i++) send_tick(0, rnd_word(), rnd_word());
            wait_drain();
        end
        for (int ph = 0; ph < 9; ph++) begin
            config_set(2);
            calm = (ph == 4);
            for (int i = 0; i < 50; i++)
                send_tick($urandom_range(15) == 0, rnd_word(), rnd_word());
            wait_drain();
        end
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire

// File: sine_joint_trajectory_pd_top.f
rtl/sjt_pkg.sv
rtl/sjt_mul.sv
rtl/sjt_cordic.sv
rtl/sjt_regs.sv
rtl/sjt_core.sv
rtl/sine_joint_trajectory_pd_top.sv
tb/tb.sv
